[rtl/header_field_value_extractor_core_assert.svh]
// assertion macros for the header field value extractor
`ifndef HEADER_FIELD_VALUE_EXTRACTOR_CORE_ASSERT_SVH
`define HEADER_FIELD_VALUE_EXTRACTOR_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define HFVE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HFVE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hfve_pkg.sv]
// shared types and constants of the header field value extractor
package hfve_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned KeyTextW = 64;
  localparam int unsigned KeyLenW  = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 64;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_KEY_TEXT   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LENGTH = 1'b1;

  // characters of interest
  localparam logic [ByteW-1:0] CHAR_CR    = 8'h0d;
  localparam logic [ByteW-1:0] CHAR_LF    = 8'h0a;
  localparam logic [ByteW-1:0] CHAR_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CHAR_TAB   = 8'h09;
  localparam logic [ByteW-1:0] CHAR_NUL   = 8'h00;

  // status codes of a result word
  localparam logic STATUS_VALUE     = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  typedef enum logic [1:0] {
    MODE_MATCH,
    MODE_SKIP,
    MODE_VALUE,
    MODE_DONE
  } mode_e;

  typedef struct packed {
    logic [ByteW-1:0] value_byte;
    logic             lookup_status;
    logic             lookup_last;
  } result_t;

endpackage

[rtl/hfve_in_if.sv]
// input channel: one buffer byte per word
interface hfve_in_if;
  logic                         valid;
  logic                         ready;
  logic [hfve_pkg::ByteW-1:0]   text_byte;
  logic                         buffer_end;

  modport source (output valid, output text_byte, output buffer_end, input ready);
  modport sink   (input valid, input text_byte, input buffer_end, output ready);
endinterface

// output channel: one value byte or status per word
interface hfve_out_if;
  logic                         valid;
  logic                         ready;
  logic [hfve_pkg::ByteW-1:0]   value_byte;
  logic                         lookup_status;
  logic                         lookup_last;

  modport source (output valid, output value_byte, output lookup_status,
                  output lookup_last, input ready);
  modport sink   (input valid, input value_byte, input lookup_status,
                  input lookup_last, output ready);
endinterface

[rtl/header_field_value_extractor_core.sv]
// header field value extractor: key match, value capture and result queue
//
// Usage: buffer bytes arrive on in_i, one byte per word, buffer_end set on the
// final byte. The key is set through the write port (index 0 key text, first
// character in the lowest byte; index 1 key length) while the block is idle.
// Results leave on out_o: value bytes of the first line whose start matches
// the key (case-insensitive, then one space or tab), or one not-found word.
// The final word of each lookup carries lookup_last; the rest of the buffer
// is then dropped until the byte with buffer_end.
// Result words of a byte are registered into the queue, behind any queued words.
// Value bytes are held back by one byte so the final one can be marked.
// Throughput: one byte per cycle while in_i.ready is high; per-byte logic is
// a single compare and state update, and a four-word result queue absorbs the
// byte that gives two words; in_i.ready drops only with three or more queued.
// Reset: empties the queue, clears the key to zero with length one and
// starts at a line start, matching.
// Stall: while out_o.ready is low the queue fills and in_i.ready falls once
// it can no longer take two words; no word is lost or repeated.
`include "header_field_value_extractor_core_assert.svh"

module header_field_value_extractor_core #(
  parameter int unsigned KEY_MAX_CHARS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hfve_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hfve_pkg::CfgDataW-1:0]  cfg_data_i,
  hfve_in_if.sink                        in_i,
  hfve_out_if.source                     out_o
);

  localparam int unsigned CntW     = $clog2(KEY_MAX_CHARS + 1);
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QCntW    = $clog2(QDepth + 1);
  localparam int unsigned QIdxW    = $clog2(QDepth);
  localparam logic [hfve_pkg::KeyLenW-1:0] KeyMaxLen = hfve_pkg::KeyLenW'(KEY_MAX_CHARS);
  localparam logic [QCntW-1:0] QReadyMax = QCntW'(QDepth - 2);

  // fold upper-case ASCII letters to lower case
  function automatic logic [hfve_pkg::ByteW-1:0] lower_ascii(
    input logic [hfve_pkg::ByteW-1:0] c
  );
    logic [hfve_pkg::ByteW-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // configuration registers
  logic [hfve_pkg::KeyTextW-1:0] key_text_q;
  logic [hfve_pkg::KeyLenW-1:0]  key_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_text_q <= '0;
      key_len_q  <= hfve_pkg::KeyLenW'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == hfve_pkg::CFG_KEY_TEXT) begin
        key_text_q <= cfg_data_i;
      end else begin
        key_len_q <= cfg_data_i[hfve_pkg::KeyLenW-1:0];
      end
    end
  end

  // parse state
  hfve_pkg::mode_e             mode_q, mode_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [hfve_pkg::ByteW-1:0]  held_q, held_d;
  logic                        held_vld_q, held_vld_d;

  // result queue
  hfve_pkg::result_t           q_q [QDepth];
  hfve_pkg::result_t           q_d [QDepth];
  logic [QCntW-1:0]            qcnt_q, qcnt_d;

  // handshake
  logic in_fire, out_fire;
  logic [hfve_pkg::ByteW-1:0] in_byte;
  logic                       in_end;

  assign in_i.ready = (qcnt_q <= QReadyMax);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign in_byte    = in_i.text_byte;
  assign in_end     = in_i.buffer_end;

  // byte classification and key compare
  logic [hfve_pkg::KeyLenW-1:0] kl;
  logic [2:0]                   key_idx;
  logic [hfve_pkg::ByteW-1:0]   key_char;
  logic                         is_break, is_blank, is_nul, key_open, key_hit;

  assign kl       = (key_len_q > KeyMaxLen) ? KeyMaxLen : key_len_q;
  assign key_idx  = 3'(cnt_q);
  assign key_char = key_text_q[hfve_pkg::ByteW*key_idx +: hfve_pkg::ByteW];
  assign is_break = (in_byte == hfve_pkg::CHAR_CR) || (in_byte == hfve_pkg::CHAR_LF);
  assign is_blank = (in_byte == hfve_pkg::CHAR_SPACE) || (in_byte == hfve_pkg::CHAR_TAB);
  assign is_nul   = (in_byte == hfve_pkg::CHAR_NUL);
  assign key_open = (kl == '0) || (hfve_pkg::KeyLenW'(cnt_q) < kl);
  assign key_hit  = (kl != '0) && (lower_ascii(in_byte) == lower_ascii(key_char));

  // next parse state
  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    if (in_fire) begin
      unique case (mode_q)
        hfve_pkg::MODE_DONE: begin
        end
        hfve_pkg::MODE_VALUE: begin
          if (is_nul || is_break) begin
            mode_d = hfve_pkg::MODE_DONE;
          end else begin
            held_d     = in_byte;
            held_vld_d = 1'b1;
          end
        end
        hfve_pkg::MODE_MATCH: begin
          if (is_nul) begin
            mode_d = hfve_pkg::MODE_DONE;
          end else if (is_break) begin
            cnt_d = '0;
          end else if (key_open) begin
            if (key_hit) begin
              cnt_d = CntW'(cnt_q + 1'b1);
            end else begin
              mode_d = hfve_pkg::MODE_SKIP;
            end
          end else if (is_blank) begin
            mode_d     = hfve_pkg::MODE_VALUE;
            held_d     = '0;
            held_vld_d = 1'b0;
          end else begin
            mode_d = hfve_pkg::MODE_SKIP;
          end
        end
        default: begin
          if (is_nul) begin
            mode_d = hfve_pkg::MODE_DONE;
          end else if (is_break) begin
            mode_d = hfve_pkg::MODE_MATCH;
            cnt_d  = '0;
          end
        end
      endcase
      // the final byte of a buffer re-arms the search
      if (in_end) begin
        mode_d     = hfve_pkg::MODE_MATCH;
        cnt_d      = '0;
        held_d     = '0;
        held_vld_d = 1'b0;
      end
    end
  end

  // result words caused by the accepted byte
  hfve_pkg::result_t res0, res1, not_found, held_res;
  logic [1:0]        n_res;

  assign not_found = '{value_byte: '0, lookup_status: hfve_pkg::STATUS_NOT_FOUND,
                       lookup_last: 1'b1};
  assign held_res  = '{value_byte: held_q, lookup_status: hfve_pkg::STATUS_VALUE,
                       lookup_last: 1'b1};

  always_comb begin
    n_res = 2'd0;
    res0  = not_found;
    res1  = not_found;
    if (in_fire && (mode_q != hfve_pkg::MODE_DONE)) begin
      if (is_nul || ((mode_q == hfve_pkg::MODE_VALUE) && is_break)) begin
        n_res = 2'd1;
        if ((mode_q == hfve_pkg::MODE_VALUE) && held_vld_q) begin
          res0 = held_res;
        end
      end else if (mode_q == hfve_pkg::MODE_VALUE) begin
        res1 = '{value_byte: in_byte, lookup_status: hfve_pkg::STATUS_VALUE,
                 lookup_last: 1'b1};
        if (held_vld_q) begin
          res0             = held_res;
          res0.lookup_last = 1'b0;
          n_res            = in_end ? 2'd2 : 2'd1;
        end else if (in_end) begin
          res0  = res1;
          n_res = 2'd1;
        end
      end else if (in_end) begin
        n_res = 2'd1;
      end
    end
  end

  // queue update: shift out at the head, append behind the survivors
  logic [QCntW-1:0] wr_pos;

  assign wr_pos = qcnt_q - QCntW'(out_fire);
  assign qcnt_d = qcnt_q - QCntW'(out_fire) + QCntW'(n_res);

  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      if (out_fire && (i < QDepth - 1)) begin
        q_d[i] = q_q[(i < QDepth - 1) ? i + 1 : i];
      end else begin
        q_d[i] = q_q[i];
      end
      if ((n_res != 2'd0) && (QCntW'(i) == wr_pos)) begin
        q_d[i] = res0;
      end else if ((n_res == 2'd2) && (QCntW'(i) == wr_pos + 1'b1)) begin
        q_d[i] = res1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= hfve_pkg::MODE_MATCH;
      cnt_q      <= '0;
      held_vld_q <= 1'b0;
      qcnt_q     <= '0;
    end else begin
      mode_q     <= mode_d;
      cnt_q      <= cnt_d;
      held_vld_q <= held_vld_d;
      qcnt_q     <= qcnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    for (int i = 0; i < QDepth; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  // output channel from the queue head
  logic [QIdxW-1:0] head_idx;

  assign head_idx            = '0;
  assign out_o.valid         = (qcnt_q != '0);
  assign out_o.value_byte    = q_q[head_idx].value_byte;
  assign out_o.lookup_status = q_q[head_idx].lookup_status;
  assign out_o.lookup_last   = q_q[head_idx].lookup_last;

  // checks
  `HFVE_ASSERT_NOW(a_qcnt_range, 1'b1, qcnt_q <= QCntW'(QDepth),
                   "result queue overflow")
  `HFVE_ASSERT_NOW(a_held_mode, held_vld_q,
                   (mode_q == hfve_pkg::MODE_VALUE) || (mode_q == hfve_pkg::MODE_DONE),
                   "held byte outside a value")
  `HFVE_ASSERT_NOW(a_not_found_word, out_o.valid && out_o.lookup_status,
                   out_o.lookup_last && (out_o.value_byte == '0),
                   "malformed not-found word")
  `HFVE_ASSERT_NEXT(a_rearm, in_fire && in_end, (mode_q == hfve_pkg::MODE_MATCH) &&
                    (cnt_q == '0) && !held_vld_q, "no re-arm after buffer end")

endmodule
